/* rtl/htc_pkg.sv */
// shared types and constants for the two-point calibrator
// no dependencies; imported by every module of the block

package htc_pkg;

    localparam int unsigned RAW_W     = 16;  // raw sample and calibration raw words
    localparam int unsigned DIFF_W    = 17;  // raw difference, one growth bit
    localparam int unsigned PT_W      = 7;   // whole-unit calibration point
    localparam int unsigned SLOPE_W   = 12;  // point difference times ten
    localparam int unsigned PROD_W    = 29;  // signed numerator
    localparam int unsigned QUO_W     = 27;  // numerator / quotient magnitude
    localparam int unsigned OFS_W     = 11;  // p0 times ten
    localparam int unsigned READING_W = 11;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned DIV_CELLS = QUO_W;

    localparam logic signed [PROD_W-1:0] READING_LIMIT = PROD_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_P0  = 4'd0,
        CFG_TEMP_P1  = 4'd1,
        CFG_TEMP_R0  = 4'd2,
        CFG_TEMP_R1  = 4'd3,
        CFG_HUM_P0   = 4'd4,
        CFG_HUM_P1   = 4'd5,
        CFG_HUM_R0   = 4'd6,
        CFG_HUM_R1   = 4'd7
    } t_cfg_idx;

    // per-request sideband that rides alongside the divider
    typedef struct packed {
        logic             channel;
        logic             bad;
        logic             sign;
        logic [OFS_W-1:0] offset;
    } t_side;

    // divider working set handed from cell to cell
    typedef struct packed {
        logic [RAW_W-1:0] rem;
        logic [QUO_W-1:0] nq;
        logic [RAW_W-1:0] den;
    } t_div;

endpackage

/* rtl/htc_front.sv */
// front end: differences, slope multiply, magnitudes
// depends on htc_pkg

module htc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_mode,
    input  logic signed [htc_pkg::RAW_W-1:0]  i_sample,
    input  logic [htc_pkg::PT_W-1:0]          i_p0,
    input  logic [htc_pkg::PT_W-1:0]          i_p1,
    input  logic signed [htc_pkg::RAW_W-1:0]  i_r0,
    input  logic signed [htc_pkg::RAW_W-1:0]  i_r1,
    output logic                              o_valid,
    output htc_pkg::t_side                    o_side,
    output htc_pkg::t_div                     o_div
);
    import htc_pkg::*;

    logic signed [DIFF_W-1:0]  n_a,  r_a;
    logic signed [DIFF_W-1:0]  n_r,  r_r;
    logic signed [SLOPE_W-1:0] n_d10, r_d10;
    logic [OFS_W-1:0]          n_ofs, r_ofs;
    logic                      r_mode, r_bad, r_v1;
    logic signed [PT_W:0]      d;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         nmag;
    logic [DIFF_W-1:0]         rmag;
    logic                      r_v2;
    t_side                     r_side;
    t_div                      r_div;

    // stage 1: differences and scaled points
    always_comb begin
        d     = $signed({1'b0, i_p1}) - $signed({1'b0, i_p0});
        n_a   = $signed({i_sample[RAW_W-1], i_sample}) - $signed({i_r0[RAW_W-1], i_r0});
        n_r   = $signed({i_r1[RAW_W-1], i_r1}) - $signed({i_r0[RAW_W-1], i_r0});
        n_d10 = SLOPE_W'($signed({{(SLOPE_W-PT_W-1){d[PT_W]}}, d}) * $signed(SLOPE_W'(10)));
        n_ofs = OFS_W'({{(OFS_W-PT_W){1'b0}}, i_p0} * OFS_W'(10));
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_r    <= n_r;
        r_d10  <= n_d10;
        r_ofs  <= n_ofs;
        r_mode <= i_mode;
        r_bad  <= (i_r1 == i_r0);
    end

    // stage 2: numerator product and sign-magnitude split
    always_comb begin
        prod = PROD_W'(r_a) * PROD_W'(r_d10);
        nmag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        rmag = r_r[DIFF_W-1] ? DIFF_W'(-r_r) : DIFF_W'(r_r);
    end

    always_ff @(posedge i_clk) begin
        r_side.channel <= r_mode;
        r_side.bad     <= r_bad;
        r_side.sign    <= prod[PROD_W-1] ^ r_r[DIFF_W-1];
        r_side.offset  <= r_ofs;
        r_div.rem      <= '0;
        r_div.nq       <= nmag[QUO_W-1:0];
        r_div.den      <= rmag[RAW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

/* rtl/htc_div_cell.sv */
// one restoring-division cell: retires one quotient bit per request
// depends on htc_pkg

module htc_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  htc_pkg::t_side i_side,
    input  htc_pkg::t_div  i_div,
    output logic           o_valid,
    output htc_pkg::t_side o_side,
    output htc_pkg::t_div  o_div
);
    import htc_pkg::*;

    logic [RAW_W:0] trial;
    logic           ge;
    t_div           n_div, r_div;
    t_side          r_side;
    logic           r_valid;

    always_comb begin
        trial     = {i_div.rem, i_div.nq[QUO_W-1]};
        ge        = (trial >= {1'b0, i_div.den});
        n_div.den = i_div.den;
        n_div.nq  = {i_div.nq[QUO_W-2:0], ge};
        n_div.rem = ge ? RAW_W'(trial - {1'b0, i_div.den}) : trial[RAW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_div  <= n_div;
        r_side <= i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;

endmodule

/* rtl/htc_post.sv */
// back end: restore sign, add offset, clamp, zero on bad calibration, output register
// depends on htc_pkg

module htc_post (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  htc_pkg::t_side                       i_side,
    input  logic [htc_pkg::QUO_W-1:0]            i_quo,
    output logic                                 o_valid,
    output logic signed [htc_pkg::READING_W-1:0] o_reading,
    output logic                                 o_channel,
    output logic                                 o_saturated,
    output logic                                 o_bad
);
    import htc_pkg::*;

    logic signed [PROD_W-1:0]    qs, sum;
    logic signed [READING_W-1:0] n_reading, r_reading;
    logic                        n_sat, r_sat, r_chan, r_bad, r_valid;

    always_comb begin
        qs  = i_side.sign ? -$signed(PROD_W'(i_quo)) : $signed(PROD_W'(i_quo));
        sum = qs + $signed(PROD_W'(i_side.offset));
        n_sat     = 1'b0;
        n_reading = sum[READING_W-1:0];
        if (i_side.bad) begin
            n_reading = '0;
        end else if (sum > READING_LIMIT) begin
            n_reading = READING_LIMIT[READING_W-1:0];
            n_sat     = 1'b1;
        end else if (sum < -READING_LIMIT) begin
            n_reading = READING_W'(-READING_LIMIT);
            n_sat     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reading <= n_reading;
        r_sat     <= n_sat;
        r_chan    <= i_side.channel;
        r_bad     <= i_side.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid     = r_valid;
    assign o_reading   = r_reading;
    assign o_channel   = r_chan;
    assign o_saturated = r_sat;
    assign o_bad       = r_bad;

endmodule

/* rtl/humidity_temperature_calibrator.sv */
// two-point linear calibrator, top level; depends on htc_pkg, htc_front,
// htc_div_cell and htc_post
// a request passes 2 front stages, 27 divider cells and 1 output register
// on its way to o_done
// throughput: one request per cycle, busy stays low; the divider is a row
// of 27 cells, one quotient bit each, so every cell holds a different request
// reset (synchronous, active low) clears the calibration registers and all
// valid flags; results leave on a one-cycle strobe the receiver cannot stall

module humidity_temperature_calibrator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request side
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_mode,
    input  logic signed [htc_pkg::RAW_W-1:0]     i_raw_sample,
    // result side
    output logic                                 o_done,
    output logic signed [htc_pkg::READING_W-1:0] o_reading_tenths,
    output logic                                 o_channel,
    output logic                                 o_saturated,
    output logic                                 o_bad_calibration,
    // calibration register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [htc_pkg::CFG_DAT_W-1:0]        i_cfg_data
);
    import htc_pkg::*;

    // calibration words, as written
    logic [9:0]       r_temp_p0, r_temp_p1;
    logic [RAW_W-1:0] r_temp_r0, r_temp_r1;
    logic [7:0]       r_hum_p0, r_hum_p1;
    logic [RAW_W-1:0] r_hum_r0, r_hum_r1;

    logic             accept;
    logic [PT_W-1:0]  sel_p0, sel_p1;
    logic [RAW_W-1:0] sel_r0, sel_r1;

    logic             cell_valid [DIV_CELLS+1];
    t_side            cell_side  [DIV_CELLS+1];
    t_div             cell_div   [DIV_CELLS+1];

    // nothing ever holds a request off
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_p0 <= '0;
            r_temp_p1 <= '0;
            r_temp_r0 <= '0;
            r_temp_r1 <= '0;
            r_hum_p0  <= '0;
            r_hum_p1  <= '0;
            r_hum_r0  <= '0;
            r_hum_r1  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TEMP_P0: r_temp_p0 <= i_cfg_data[9:0];
                CFG_TEMP_P1: r_temp_p1 <= i_cfg_data[9:0];
                CFG_TEMP_R0: r_temp_r0 <= i_cfg_data;
                CFG_TEMP_R1: r_temp_r1 <= i_cfg_data;
                CFG_HUM_P0:  r_hum_p0  <= i_cfg_data[7:0];
                CFG_HUM_P1:  r_hum_p1  <= i_cfg_data[7:0];
                CFG_HUM_R0:  r_hum_r0  <= i_cfg_data;
                CFG_HUM_R1:  r_hum_r1  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel select; temperature points drop 3 fraction bits, humidity 1
    always_comb begin
        if (i_mode) begin
            sel_p0 = r_hum_p0[7:1];
            sel_p1 = r_hum_p1[7:1];
            sel_r0 = r_hum_r0;
            sel_r1 = r_hum_r1;
        end else begin
            sel_p0 = r_temp_p0[9:3];
            sel_p1 = r_temp_p1[9:3];
            sel_r0 = r_temp_r0;
            sel_r1 = r_temp_r1;
        end
    end

    htc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_mode   (i_mode),
        .i_sample (i_raw_sample),
        .i_p0     (sel_p0),
        .i_p1     (sel_p1),
        .i_r0     ($signed(sel_r0)),
        .i_r1     ($signed(sel_r1)),
        .o_valid  (cell_valid[0]),
        .o_side   (cell_side[0]),
        .o_div    (cell_div[0])
    );

    // divider row: each cell shifts in one numerator bit and emits one quotient bit
    for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
        htc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (cell_valid[g]),
            .i_side  (cell_side[g]),
            .i_div   (cell_div[g]),
            .o_valid (cell_valid[g+1]),
            .o_side  (cell_side[g+1]),
            .o_div   (cell_div[g+1])
        );
    end

    // after the last cell the shift register holds the quotient magnitude
    htc_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cell_valid[DIV_CELLS]),
        .i_side      (cell_side[DIV_CELLS]),
        .i_quo       (cell_div[DIV_CELLS].nq),
        .o_valid     (o_done),
        .o_reading   (o_reading_tenths),
        .o_channel   (o_channel),
        .o_saturated (o_saturated),
        .o_bad       (o_bad_calibration)
    );

`ifndef NO_ASSERTIONS
    // every accepted request comes out on o_done after the front, divider row and output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##30 o_done)
        else $error("result strobe missing after fixed latency");

    // a bad calibration never reports a clamp and always reads zero
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_calibration) |-> (!o_saturated && o_reading_tenths == 0))
        else $error("bad calibration result not zero");

    // a clamped reading sits exactly on a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |->
            (o_reading_tenths == 11'sd1000 || o_reading_tenths == -11'sd1000))
        else $error("saturated reading off the limit");

    // an unclamped reading stays inside the limits
    a_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_saturated) |->
            (o_reading_tenths <= 11'sd1000 && o_reading_tenths >= -11'sd1000))
        else $error("unclamped reading out of range");
`endif

endmodule
